@@ design/u8d_pkg.sv @@
// Package for the UTF-8 stream decoder/validator.
// Holds result status codes, result and decode-stage structs, queue sizing constants
// and the minimum code point per sequence length. No dependencies.
package u8d_pkg;

    typedef enum logic [1:0] {
        ST_DONE       = 2'd0,
        ST_BROKEN     = 2'd1,
        ST_INCOMPLETE = 2'd2
    } status_t;

    typedef struct packed {
        logic [20:0] code_point;
        status_t     status;
        logic [2:0]  byte_count;
        logic        last_in_run;
    } result_t;

    // Up to two results per input beat; count is 0..2.
    typedef struct packed {
        logic [1:0] count;
        result_t    res0;
        result_t    res1;
    } decode_out_t;

    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned PTR_W      = 2;
    localparam int unsigned CNT_W      = 3;

    localparam logic [20:0] MIN_LEN2 = 21'h00080;
    localparam logic [20:0] MIN_LEN3 = 21'h00800;
    localparam logic [20:0] MIN_LEN4 = 21'h10000;

    function automatic logic [20:0] min_value(input logic [2:0] len);
        logic [20:0] v;
        unique case (len)
            3'd2:    v = MIN_LEN2;
            3'd3:    v = MIN_LEN3;
            3'd4:    v = MIN_LEN4;
            default: v = 21'd0;
        endcase
        return v;
    endfunction

endpackage

@@ design/u8d_decode.sv @@
// Sequence decoder: running sequence state plus single-pass decode of one byte.
// Produces zero to two results per accepted beat. Depends on u8d_pkg.
module u8d_decode
    import u8d_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic [7:0]  byte_in,
    input  logic        end_of_text,
    output decode_out_t dec
);

    logic [2:0]  exp_len_reg, exp_len_next;
    logic [2:0]  seen_reg, seen_next;
    logic [20:0] part_reg, part_next;

    logic        seq_open;
    logic [2:0]  lead_len;
    logic [20:0] lead_bits;
    logic        st_emit;
    result_t     st_res;
    logic [2:0]  st_exp_len;
    logic [2:0]  st_seen;
    logic [20:0] st_part;
    logic [20:0] acc_cp;
    logic [2:0]  acc_seen;
    result_t     r0, r1;
    logic [1:0]  n_res;

    always_comb
    begin
        priority if (byte_in < 8'h80)
            lead_len = 3'd1;
        else if (byte_in < 8'hC0)
            lead_len = 3'd0;
        else if (byte_in < 8'hE0)
            lead_len = 3'd2;
        else if (byte_in < 8'hF0)
            lead_len = 3'd3;
        else if (byte_in < 8'hF8)
            lead_len = 3'd4;
        else
            lead_len = 3'd0;
    end

    always_comb
    begin
        unique case (lead_len)
            3'd2:    lead_bits = {16'd0, byte_in[4:0]};
            3'd3:    lead_bits = {17'd0, byte_in[3:0]};
            default: lead_bits = {18'd0, byte_in[2:0]};
        endcase
    end

    // Byte taken as the lead of a new sequence.
    always_comb
    begin
        st_emit    = 1'b0;
        st_res     = '0;
        st_exp_len = 3'd0;
        st_seen    = 3'd0;
        st_part    = 21'd0;
        if (lead_len == 3'd0)
        begin
            st_emit           = 1'b1;
            st_res.status     = ST_BROKEN;
            st_res.byte_count = 3'd1;
        end
        else if (lead_len == 3'd1)
        begin
            st_emit           = 1'b1;
            st_res.code_point = {13'd0, byte_in};
            st_res.status     = ST_DONE;
            st_res.byte_count = 3'd1;
        end
        else if (end_of_text)
        begin
            st_emit           = 1'b1;
            st_res.status     = ST_INCOMPLETE;
            st_res.byte_count = 3'd1;
        end
        else
        begin
            st_exp_len = lead_len;
            st_seen    = 3'd1;
            st_part    = lead_bits;
        end
    end

    assign seq_open = (exp_len_reg >= 3'd2) && (exp_len_reg <= 3'd4) &&
                      (seen_reg != 3'd0) && (seen_reg < exp_len_reg);
    assign acc_cp   = {part_reg[14:0], byte_in[5:0]};
    assign acc_seen = seen_reg + 3'd1;

    always_comb
    begin
        r0           = '0;
        r1           = '0;
        n_res        = 2'd0;
        exp_len_next = 3'd0;
        seen_next    = 3'd0;
        part_next    = 21'd0;
        if (!seq_open)
        begin
            r0           = st_res;
            n_res        = {1'b0, st_emit};
            exp_len_next = st_exp_len;
            seen_next    = st_seen;
            part_next    = st_part;
        end
        else if (byte_in[7:6] == 2'b10)
        begin
            if (acc_seen == exp_len_reg)
            begin
                n_res         = 2'd1;
                r0.byte_count = exp_len_reg;
                if (acc_cp < min_value(exp_len_reg))
                    r0.status = ST_BROKEN;
                else
                begin
                    r0.status     = ST_DONE;
                    r0.code_point = acc_cp;
                end
            end
            else if (end_of_text)
            begin
                n_res         = 2'd1;
                r0.status     = ST_INCOMPLETE;
                r0.byte_count = acc_seen;
            end
            else
            begin
                exp_len_next = exp_len_reg;
                seen_next    = acc_seen;
                part_next    = acc_cp;
            end
        end
        else
        begin
            // cut short: report held bytes, then restart on this byte
            r0.status     = ST_BROKEN;
            r0.byte_count = seen_reg;
            r1            = st_res;
            n_res         = st_emit ? 2'd2 : 2'd1;
            exp_len_next  = st_exp_len;
            seen_next     = st_seen;
            part_next     = st_part;
        end
        if (n_res == 2'd1)
            r0.last_in_run = 1'b1;
        if (n_res == 2'd2)
            r1.last_in_run = 1'b1;
    end

    assign dec.count = n_res;
    assign dec.res0  = r0;
    assign dec.res1  = r1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_len_reg <= 3'd0;
            seen_reg    <= 3'd0;
            part_reg    <= 21'd0;
        end
        else if (accept)
        begin
            exp_len_reg <= exp_len_next;
            seen_reg    <= seen_next;
            part_reg    <= part_next;
        end
    end

`ifndef SYNTHESIS
    a_state_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        (exp_len_reg == 3'd0) || (seen_reg != 3'd0 && seen_reg < exp_len_reg &&
        exp_len_reg <= 3'd4))
        else $error("sequence state out of range");

    a_two_means_broken_first: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && dec.count == 2'd2) |-> (dec.res0.status == ST_BROKEN &&
        !dec.res0.last_in_run))
        else $error("double result without broken first report");

    a_single_marked_last: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && dec.count == 2'd1) |-> dec.res0.last_in_run)
        else $error("single result not marked last");
`endif

endmodule

@@ design/u8d_result_fifo.sv @@
// Result queue: takes up to two results per cycle, hands out one per beat.
// Four-entry register queue; asks for a stall when fewer than two slots are free.
// Depends on u8d_pkg.
module u8d_result_fifo
    import u8d_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  decode_out_t dec,
    output logic        full_pair,
    output logic        out_valid,
    input  logic        out_stall,
    output result_t     head
);

    result_t           slot_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]  wr_reg, wr_next;
    logic [PTR_W-1:0]  rd_reg, rd_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [1:0]        push_n;
    logic              pop;
    logic [PTR_W-1:0]  wr_plus1;

    assign push_n    = push ? dec.count : 2'd0;
    assign out_valid = (cnt_reg != '0);
    assign pop       = out_valid && !out_stall;
    assign full_pair = (cnt_reg > CNT_W'(FIFO_DEPTH - 2));
    assign head      = slot_reg[rd_reg];
    assign wr_plus1  = wr_reg + PTR_W'(1);

    always_comb
    begin
        wr_next  = wr_reg + PTR_W'(push_n);
        rd_next  = rd_reg + PTR_W'(pop);
        cnt_next = cnt_reg + CNT_W'(push_n) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
            slot_reg[wr_reg] <= dec.res0;
        if (push_n == 2'd2)
            slot_reg[wr_plus1] <= dec.res1;
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(FIFO_DEPTH))
        else $error("result queue overflow");

    a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == CNT_W'(FIFO_DEPTH)) || (cnt_reg[PTR_W-1:0] == (wr_reg - rd_reg)))
        else $error("queue count and pointers disagree");

    a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (push_n == 2'd0 && !pop) |=> $stable(cnt_reg))
        else $error("queue count moved without push or pop");
`endif

endmodule

@@ design/utf8_stream_decoder_validator_core.sv @@
// Top level of the UTF-8 stream decoder/validator.
// Instantiates u8d_decode and u8d_result_fifo; depends on u8d_pkg.
//
//   channel | handshake          | payload
//   in      | in_valid, in_stall | byte_in, end_of_text
//   out     | out_valid, out_stall | code_point, status, byte_count, last_in_run
//
// One byte is decoded per unstalled cycle in a single pass over the sequence state registers.
// Results are registered into a four-entry queue in the cycle after the byte is taken.
// A byte that ends a cut-short sequence can give two results; the queue drains one per beat,
// so sustained rate is one byte per cycle only with out_stall low and no double results.
// in_stall rises while fewer than two queue slots are free. Reset is async, active low.
module utf8_stream_decoder_validator_core
    import u8d_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  byte_in,
    input  logic        end_of_text,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [20:0] code_point,
    output logic [1:0]  status,
    output logic [2:0]  byte_count,
    output logic        last_in_run
);

    logic        accept;
    logic        full_pair;
    decode_out_t dec;
    result_t     head;

    assign in_stall = full_pair;
    assign accept   = in_valid && !full_pair;

    u8d_decode u_decode (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .byte_in     (byte_in),
        .end_of_text (end_of_text),
        .dec         (dec)
    );

    u8d_result_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .dec       (dec),
        .full_pair (full_pair),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .head      (head)
    );

    assign code_point  = head.code_point;
    assign status      = head.status;
    assign byte_count  = head.byte_count;
    assign last_in_run = head.last_in_run;

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// Testbench for utf8_stream_decoder_validator_core: directed and random UTF-8 byte streams,
// with results predicted by a decoder model held in the bench and checked beat by beat.
// Depends on u8d_pkg and the design sources.
module testbench;
    import u8d_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  byte_in = 8'h00;
    logic        end_of_text = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [20:0] code_point;
    logic [1:0]  status;
    logic [2:0]  byte_count;
    logic        last_in_run;

    result_t     expected_q[$];
    logic [2:0]  seq_len = 3'd0;
    logic [2:0]  seq_have = 3'd0;
    logic [20:0] seq_acc = 21'd0;
    int          mismatches = 0;
    int          burst_left = 8;
    int          bytes_sent = 0;
    bit          valid_held = 1'b0;
    logic [15:0] stall_tick = 16'd0;
    logic [1:0]  stall_mode = 2'd0;

    utf8_stream_decoder_validator_core i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .byte_in     (byte_in),
        .end_of_text (end_of_text),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .code_point  (code_point),
        .status      (status),
        .byte_count  (byte_count),
        .last_in_run (last_in_run)
    );

    always #6 clk = ~clk;

    function automatic logic [2:0] lead_length(input logic [7:0] b);
        if (b < 8'h80)
            return 3'd1;
        if (b < 8'hC0)
            return 3'd0;
        if (b < 8'hE0)
            return 3'd2;
        if (b < 8'hF0)
            return 3'd3;
        if (b < 8'hF8)
            return 3'd4;
        return 3'd0;
    endfunction

    task automatic push_result(input logic [20:0] cp, input status_t st, input logic [2:0] cnt);
        result_t r;
        r.code_point  = cp;
        r.status      = st;
        r.byte_count  = cnt;
        r.last_in_run = 1'b0;
        expected_q.push_back(r);
    endtask

    task automatic open_sequence(input logic [7:0] b, input logic eot);
        logic [2:0] len;
        len      = lead_length(b);
        seq_len  = 3'd0;
        seq_have = 3'd0;
        seq_acc  = 21'd0;
        if (len == 3'd0)
            push_result(21'd0, ST_BROKEN, 3'd1);
        else if (len == 3'd1)
            push_result({13'd0, b}, ST_DONE, 3'd1);
        else
        begin
            seq_len  = len;
            seq_have = 3'd1;
            case (len)
                3'd2:    seq_acc = {16'd0, b[4:0]};
                3'd3:    seq_acc = {17'd0, b[3:0]};
                default: seq_acc = {18'd0, b[2:0]};
            endcase
            if (eot)
            begin
                push_result(21'd0, ST_INCOMPLETE, seq_have);
                seq_len  = 3'd0;
                seq_have = 3'd0;
                seq_acc  = 21'd0;
            end
        end
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic eot);
        int          prior;
        result_t     r;
        logic [20:0] floor_cp;
        prior = expected_q.size();
        if (seq_len == 3'd0)
            open_sequence(b, eot);
        else if (b[7:6] == 2'b10)
        begin
            seq_acc  = {seq_acc[14:0], b[5:0]};
            seq_have = seq_have + 3'd1;
            if (seq_have == seq_len)
            begin
                case (seq_len)
                    3'd2:    floor_cp = MIN_LEN2;
                    3'd3:    floor_cp = MIN_LEN3;
                    default: floor_cp = MIN_LEN4;
                endcase
                if (seq_acc < floor_cp)
                    push_result(21'd0, ST_BROKEN, seq_len);
                else
                    push_result(seq_acc, ST_DONE, seq_len);
                seq_len  = 3'd0;
                seq_have = 3'd0;
                seq_acc  = 21'd0;
            end
            else if (eot)
            begin
                push_result(21'd0, ST_INCOMPLETE, seq_have);
                seq_len  = 3'd0;
                seq_have = 3'd0;
                seq_acc  = 21'd0;
            end
        end
        else
        begin
            // cut short: old sequence broken, this byte starts a new one
            push_result(21'd0, ST_BROKEN, seq_have);
            open_sequence(b, eot);
        end
        if (expected_q.size() > prior)
        begin
            r = expected_q.pop_back();
            r.last_in_run = 1'b1;
            expected_q.push_back(r);
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic eot);
        in_valid    <= 1'b1;
        byte_in     <= b;
        end_of_text <= eot;
        valid_held = 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        decode_byte(b, eot);
        bytes_sent++;
        burst_left--;
        if (burst_left <= 0)
        begin
            in_valid <= 1'b0;
            valid_held = 1'b0;
            repeat ($urandom_range(1, 6))
                @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
        end
    endtask

    task automatic test_ascii();
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b0);
    endtask

    task automatic test_multibyte();
        send_byte(8'hC2, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hE0, 1'b0);
        send_byte(8'hA0, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hF7, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b0);
    endtask

    task automatic test_invalid_lead();
        send_byte(8'h80, 1'b0);
        send_byte(8'hF8, 1'b0);
        send_byte(8'hFF, 1'b0);
    endtask

    task automatic test_overlong();
        send_byte(8'hC1, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hE0, 1'b0);
        send_byte(8'h9F, 1'b0);
        send_byte(8'hBF, 1'b0);
    endtask

    task automatic test_bad_continuation();
        send_byte(8'hE2, 1'b0);
        send_byte(8'h41, 1'b0);
    endtask

    task automatic test_open_at_end();
        send_byte(8'hC3, 1'b1);
        send_byte(8'hE2, 1'b0);
        send_byte(8'h82, 1'b1);
        send_byte(8'hF0, 1'b0);
        send_byte(8'hC3, 1'b1);
    endtask

    task automatic test_random_text();
        logic [20:0] cp;
        logic [7:0]  enc[4];
        int          len;
        int          keep;
        int          kind;
        int          start;
        int          i;
        logic        eot;
        start = bytes_sent;
        while (bytes_sent - start < 1000)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 10)
                send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 29) == 0);
            else
            begin
                len  = (kind < 30) ? $urandom_range(2, 4) : $urandom_range(1, 4);
                keep = len;
                if (kind < 20)
                begin
                    case (len)
                        2:       cp = 21'($urandom_range(0, 'h7F));
                        3:       cp = 21'($urandom_range(0, 'h7FF));
                        default: cp = 21'($urandom_range(0, 'hFFFF));
                    endcase
                end
                else
                begin
                    case (len)
                        1:       cp = 21'($urandom_range(0, 'h7F));
                        2:       cp = 21'($urandom_range('h80, 'h7FF));
                        3:       cp = 21'($urandom_range('h800, 'hFFFF));
                        default: cp = 21'($urandom_range('h10000, 'h1FFFFF));
                    endcase
                    if (kind < 30)
                        keep = $urandom_range(1, len - 1);
                end
                case (len)
                    1:
                    begin
                        enc[0] = cp[7:0];
                    end
                    2:
                    begin
                        enc[0] = {3'b110, cp[10:6]};
                        enc[1] = {2'b10, cp[5:0]};
                    end
                    3:
                    begin
                        enc[0] = {4'b1110, cp[15:12]};
                        enc[1] = {2'b10, cp[11:6]};
                        enc[2] = {2'b10, cp[5:0]};
                    end
                    default:
                    begin
                        enc[0] = {5'b11110, cp[20:18]};
                        enc[1] = {2'b10, cp[17:12]};
                        enc[2] = {2'b10, cp[11:6]};
                        enc[3] = {2'b10, cp[5:0]};
                    end
                endcase
                for (i = 0; i < keep; i++)
                begin
                    if (kind >= 20 && kind < 30 && i == keep - 1)
                        eot = 1'($urandom_range(0, 1));
                    else
                        eot = ($urandom_range(0, 29) == 0);
                    send_byte(enc[i], eot);
                end
            end
        end
    endtask

    // receiver stall pattern, mode reselected at random from a tick counter
    always @(posedge clk)
    begin
        stall_tick <= stall_tick + 16'd1;
        if (stall_tick % 97 == 0)
            stall_mode <= 2'($urandom_range(0, 3));
        case (stall_mode)
            2'd0:    out_stall <= 1'b0;
            2'd1:    out_stall <= ($urandom_range(0, 3) == 0);
            2'd2:    out_stall <= ($urandom_range(0, 9) < 7);
            default: out_stall <= (stall_tick[3:0] < 4'd11);
        endcase
    end

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: cp=%06h status=%0d count=%0d last=%0d",
                             code_point, status, byte_count, last_in_run);
            end
            else
            begin
                want = expected_q.pop_front();
                if (code_point !== want.code_point || status !== want.status ||
                    byte_count !== want.byte_count || last_in_run !== want.last_in_run)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp cp=%06h status=%0d count=%0d last=%0d,",
                                  " got cp=%06h status=%0d count=%0d last=%0d"},
                                 want.code_point, want.status, want.byte_count,
                                 want.last_in_run, code_point, status, byte_count,
                                 last_in_run);
                end
            end
        end
    end

    initial
    begin
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_ascii();
        test_multibyte();
        test_invalid_lead();
        test_overlong();
        test_bad_continuation();
        test_open_at_end();
        test_random_text();
        if (valid_held)
        begin
            in_valid <= 1'b0;
            valid_held = 1'b0;
        end
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (10)
            @(posedge clk);
        if (mismatches == 0 && expected_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

@@ utf8_stream_decoder_validator_core.f @@
design/u8d_pkg.sv
design/u8d_decode.sv
design/u8d_result_fifo.sv
design/utf8_stream_decoder_validator_core.sv
bench/testbench.sv
